// ----- hdl/imufd_pkg.sv -----
// Shared types and constants for the IMU FIFO frame decoder.
package imufd_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ACCEL_W = 21;
    localparam int unsigned GYRO_W  = 37;
    localparam int unsigned OPA_W   = 27;
    localparam int unsigned OPB_W   = 12;
    localparam int unsigned PROD_W  = OPA_W + OPB_W;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_AXIS  = 2'd2;

    // marker words
    localparam logic [WORD_W-1:0] OVERREAD_WORD  = 16'h8000;
    localparam logic [WORD_W-1:0] INVALID_LOW    = 16'h8000;
    localparam logic [WORD_W-1:0] ACCEL_INV_WORD = 16'h7F01;
    localparam logic [WORD_W-1:0] GYRO_INV_WORD  = 16'h7F02;

    // multiplier passes, in issue order
    localparam logic [STEP_W-1:0] STEP_ACC_Y  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ACC_X  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ACC_Z  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CROSS  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_GYR_X  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_GYR_Y  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_GYR_Z  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_FLUSH  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] issue_step;
        logic              wr;
        logic [STEP_W-1:0] wr_step;
    } seq_ctrl_t;

endpackage

// ----- hdl/imufd_frame_if.sv -----
// Input frame channel and result channel interfaces.
interface imufd_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] gyro_word_x;
    logic [15:0] gyro_word_y;
    logic [15:0] gyro_word_z;
    logic [15:0] accel_word_x;
    logic [15:0] accel_word_y;
    logic [15:0] accel_word_z;

    modport source (output valid, output gyro_word_x, output gyro_word_y,
                    output gyro_word_z, output accel_word_x, output accel_word_y,
                    output accel_word_z, input ready);
    modport sink (input valid, input gyro_word_x, input gyro_word_y,
                  input gyro_word_z, input accel_word_x, input accel_word_y,
                  input accel_word_z, output ready);
endinterface

interface imufd_result_if;
    logic               valid;
    logic               ready;
    logic               frame_skipped;
    logic               accel_fresh;
    logic               gyro_fresh;
    logic signed [20:0] accel_out_x;
    logic signed [20:0] accel_out_y;
    logic signed [20:0] accel_out_z;
    logic signed [36:0] gyro_out_x;
    logic signed [36:0] gyro_out_y;
    logic signed [36:0] gyro_out_z;

    modport source (output valid, output frame_skipped, output accel_fresh,
                    output gyro_fresh, output accel_out_x, output accel_out_y,
                    output accel_out_z, output gyro_out_x, output gyro_out_y,
                    output gyro_out_z, input ready);
    modport sink (input valid, input frame_skipped, input accel_fresh,
                  input gyro_fresh, input accel_out_x, input accel_out_y,
                  input accel_out_z, input gyro_out_x, input gyro_out_y,
                  input gyro_out_z, output ready);
endinterface

// ----- hdl/imu_fifo_frame_decoder.sv -----
// Top level: IMU FIFO frame decoder with one shared multiplier.
// The result is valid in ST_DONE, after the multiplier passes for the accepted frame.
// A new frame is taken only in ST_IDLE, once the last result is taken; each frame makes
// seven passes through the single multiplier plus a final write-back step.
// Reset: held outputs clear to zero, ranges to code 3, cross-axis factor to 0.
module imu_fifo_frame_decoder
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    imufd_frame_if.sink                            frame,
    imufd_result_if.source                         result,
    input  logic                                   cfg_we,
    input  logic [imufd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imufd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    imufd_pkg::seq_ctrl_t ctrl;

    logic [1:0]        accel_range_reg;
    logic [1:0]        gyro_range_reg;
    logic signed [6:0] cross_axis_reg;

    logic [15:0] gx_reg, gy_reg, gz_reg, ax_reg, ay_reg, az_reg;
    logic        skip_reg, accel_ok_reg, gyro_ok_reg;

    logic signed [imufd_pkg::ACCEL_W-1:0] held_accel_reg [3];
    logic signed [imufd_pkg::GYRO_W-1:0]  held_gyro_reg  [3];
    logic signed [imufd_pkg::OPA_W-1:0]   corr_reg;

    logic signed [imufd_pkg::OPA_W-1:0]   op_a;
    logic signed [imufd_pkg::OPB_W-1:0]   op_b;
    logic signed [imufd_pkg::PROD_W-1:0]  prod;
    logic signed [imufd_pkg::OPB_W-1:0]   accel_gain;
    logic signed [imufd_pkg::OPB_W-1:0]   gyro_gain;
    logic signed [imufd_pkg::OPA_W-1:0]   gx_scaled;

    logic skip_next, accel_bad, gyro_bad;

    imufd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    imufd_mul u_mul
    (
        .clk  (clk),
        .en   (ctrl.issue),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg <= 2'd3;
            gyro_range_reg  <= 2'd3;
            cross_axis_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imufd_pkg::CFG_ACCEL_RANGE: accel_range_reg <= cfg_data[1:0];
                imufd_pkg::CFG_GYRO_RANGE:  gyro_range_reg  <= cfg_data[1:0];
                imufd_pkg::CFG_CROSS_AXIS:  cross_axis_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame classification
    always_comb
    begin
        skip_next = (frame.gyro_word_x == imufd_pkg::OVERREAD_WORD);
        accel_bad = (frame.accel_word_x == imufd_pkg::ACCEL_INV_WORD) &&
                    (frame.accel_word_y == imufd_pkg::INVALID_LOW) &&
                    (frame.accel_word_z == imufd_pkg::INVALID_LOW);
        gyro_bad  = (frame.gyro_word_x == imufd_pkg::GYRO_INV_WORD) &&
                    (frame.gyro_word_y == imufd_pkg::INVALID_LOW) &&
                    (frame.gyro_word_z == imufd_pkg::INVALID_LOW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg     <= 1'b0;
            accel_ok_reg <= 1'b0;
            gyro_ok_reg  <= 1'b0;
        end
        else if (ctrl.load)
        begin
            skip_reg     <= skip_next;
            accel_ok_reg <= !skip_next && !accel_bad;
            gyro_ok_reg  <= !skip_next && !gyro_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            gx_reg <= frame.gyro_word_x;
            gy_reg <= frame.gyro_word_y;
            gz_reg <= frame.gyro_word_z;
            ax_reg <= frame.accel_word_x;
            ay_reg <= frame.accel_word_y;
            az_reg <= frame.accel_word_z;
        end
    end

    // operand select
    always_comb
    begin
        accel_gain = imufd_pkg::OPB_W'(5'd2 << accel_range_reg);
        gyro_gain  = imufd_pkg::OPB_W'(11'd250 << gyro_range_reg);
        gx_scaled  = {{2{gx_reg[15]}}, gx_reg, 9'd0};
        op_a = '0;
        op_b = '0;
        case (ctrl.issue_step)
            imufd_pkg::STEP_ACC_Y:
            begin
                op_a = imufd_pkg::OPA_W'(0) - {{11{ay_reg[15]}}, ay_reg};
                op_b = accel_gain;
            end
            imufd_pkg::STEP_ACC_X:
            begin
                op_a = {{11{ax_reg[15]}}, ax_reg};
                op_b = accel_gain;
            end
            imufd_pkg::STEP_ACC_Z:
            begin
                op_a = {{11{az_reg[15]}}, az_reg};
                op_b = accel_gain;
            end
            imufd_pkg::STEP_CROSS:
            begin
                op_a = {{11{gz_reg[15]}}, gz_reg};
                op_b = {{5{cross_axis_reg[6]}}, cross_axis_reg};
            end
            imufd_pkg::STEP_GYR_X:
            begin
                op_a = imufd_pkg::OPA_W'(0) - {{2{gy_reg[15]}}, gy_reg, 9'd0};
                op_b = gyro_gain;
            end
            imufd_pkg::STEP_GYR_Y:
            begin
                op_a = corr_reg;
                op_b = gyro_gain;
            end
            imufd_pkg::STEP_GYR_Z:
            begin
                op_a = {{2{gz_reg[15]}}, gz_reg, 9'd0};
                op_b = gyro_gain;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // write-back of the previous pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_accel_reg[i] <= '0;
                held_gyro_reg[i]  <= '0;
            end
        end
        else if (ctrl.wr)
        begin
            case (ctrl.wr_step)
                imufd_pkg::STEP_ACC_Y:
                    if (accel_ok_reg) held_accel_reg[0] <= prod[imufd_pkg::ACCEL_W-1:0];
                imufd_pkg::STEP_ACC_X:
                    if (accel_ok_reg) held_accel_reg[1] <= prod[imufd_pkg::ACCEL_W-1:0];
                imufd_pkg::STEP_ACC_Z:
                    if (accel_ok_reg) held_accel_reg[2] <= prod[imufd_pkg::ACCEL_W-1:0];
                imufd_pkg::STEP_GYR_X:
                    if (gyro_ok_reg) held_gyro_reg[0] <= prod[imufd_pkg::GYRO_W-1:0];
                imufd_pkg::STEP_GYR_Y:
                    if (gyro_ok_reg) held_gyro_reg[1] <= prod[imufd_pkg::GYRO_W-1:0];
                imufd_pkg::STEP_GYR_Z:
                    if (gyro_ok_reg) held_gyro_reg[2] <= prod[imufd_pkg::GYRO_W-1:0];
                default: ;
            endcase
        end
    end

    // cross-axis corrected x: raw_x*512 - raw_z*factor
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && (ctrl.wr_step == imufd_pkg::STEP_CROSS))
        begin
            corr_reg <= gx_scaled - prod[imufd_pkg::OPA_W-1:0];
        end
    end

    assign result.frame_skipped = skip_reg;
    assign result.accel_fresh   = accel_ok_reg;
    assign result.gyro_fresh    = gyro_ok_reg;
    assign result.accel_out_x   = held_accel_reg[0];
    assign result.accel_out_y   = held_accel_reg[1];
    assign result.accel_out_z   = held_accel_reg[2];
    assign result.gyro_out_x    = held_gyro_reg[0];
    assign result.gyro_out_y    = held_gyro_reg[1];
    assign result.gyro_out_z    = held_gyro_reg[2];

endmodule

// ----- hdl/imufd_mul.sv -----
// Shared signed multiplier with registered product.
module imufd_mul
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [imufd_pkg::OPA_W-1:0]     op_a,
    input  logic signed [imufd_pkg::OPB_W-1:0]     op_b,
    output logic signed [imufd_pkg::PROD_W-1:0]    prod
);

    logic signed [imufd_pkg::PROD_W-1:0] prod_reg;
    logic signed [imufd_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = imufd_pkg::PROD_W'(op_a) * imufd_pkg::PROD_W'(op_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/imufd_ctrl.sv -----
// Sequencer: handshakes and multiplier pass schedule.
module imufd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output imufd_pkg::seq_ctrl_t  ctrl
);

    imufd_pkg::state_t                state_reg;
    imufd_pkg::state_t                state_next;
    logic [imufd_pkg::STEP_W-1:0]     step_reg;
    logic [imufd_pkg::STEP_W-1:0]     step_next;

    assign in_ready  = (state_reg == imufd_pkg::ST_IDLE);
    assign out_valid = (state_reg == imufd_pkg::ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            imufd_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = imufd_pkg::ST_CALC;
                end
            end
            imufd_pkg::ST_CALC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == imufd_pkg::STEP_FLUSH)
                begin
                    state_next = imufd_pkg::ST_DONE;
                end
            end
            imufd_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = imufd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imufd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imufd_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        ctrl.load       = in_valid && in_ready;
        ctrl.issue      = (state_reg == imufd_pkg::ST_CALC) &&
                          (step_reg != imufd_pkg::STEP_FLUSH);
        ctrl.issue_step = step_reg;
        ctrl.wr         = (state_reg == imufd_pkg::ST_CALC) && (step_reg != '0);
        ctrl.wr_step    = step_reg - 1'b1;
    end

endmodule
